### rtl/ths_pkg.sv
`timescale 1ns / 1ps

package ths_pkg;

   // grid and fixed-point sizing
   localparam int GRID_SIDE_MAX = 256;
   localparam int FRAC_BITS     = 8;
   localparam int SCALE_FRAC    = 24;
   localparam int SIDE_MIN      = 2;

   localparam int POS_BITS    = 24;
   localparam int UPOS_BITS   = 23;
   localparam int HEIGHT_BITS = 24;
   localparam int SCALE_BITS  = 24;
   localparam int SIDE_BITS   = 9;
   localparam int IDX_BITS    = $clog2(GRID_SIDE_MAX);
   localparam int ADDR_BITS   = 16;
   localparam int GRID_BITS   = UPOS_BITS + SCALE_BITS;
   localparam int INT_BITS    = GRID_BITS - SCALE_FRAC;
   localparam int BLEND_BITS  = HEIGHT_BITS + FRAC_BITS + 2;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;

   // half a world unit in Q15.8
   localparam logic [UPOS_BITS-1:0] POS_HALF = UPOS_BITS'(128);

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_SCALE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WORLD_SIZE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_SIDE  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAM_HEIGHT = 2'd3;

   // register reset values
   localparam logic [SCALE_BITS-1:0] INV_SCALE_RESET  = SCALE_BITS'(65536);
   localparam logic [UPOS_BITS-1:0]  WORLD_SIZE_RESET = UPOS_BITS'(65536);
   localparam logic [SIDE_BITS-1:0]  GRID_SIDE_RESET  = SIDE_BITS'(GRID_SIDE_MAX);

   // saturation bounds
   localparam logic signed [HEIGHT_BITS-1:0] H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
   localparam logic signed [HEIGHT_BITS-1:0] H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};

   // configuration as seen by the datapath
   typedef struct packed {
      logic        [SCALE_BITS-1:0]  inv_scale;
      logic        [UPOS_BITS-1:0]   world_size;
      logic        [SIDE_BITS-1:0]   side;
      logic        [IDX_BITS-1:0]    side_m1;
      logic signed [HEIGHT_BITS-1:0] cam_height;
   } cfg_type;

   // word leaving the coordinate pipe towards the height store
   typedef struct packed {
      logic                   is_query;
      logic [ADDR_BITS-1:0]   wr_addr;
      logic [HEIGHT_BITS-1:0] wr_data;
      logic [UPOS_BITS-1:0]   px;
      logic [UPOS_BITS-1:0]   pz;
      logic [ADDR_BITS-1:0]   a00;
      logic [ADDR_BITS-1:0]   a10;
      logic [ADDR_BITS-1:0]   a01;
      logic [ADDR_BITS-1:0]   a11;
      logic                   corner;
      logic [FRAC_BITS-1:0]   fx;
      logic [FRAC_BITS-1:0]   fz;
   } addr_word_type;

   // word carrying the four neighbour samples into the blend pipe
   typedef struct packed {
      logic        [UPOS_BITS-1:0]   px;
      logic        [UPOS_BITS-1:0]   pz;
      logic signed [HEIGHT_BITS-1:0] h00;
      logic signed [HEIGHT_BITS-1:0] h10;
      logic signed [HEIGHT_BITS-1:0] h01;
      logic signed [HEIGHT_BITS-1:0] h11;
      logic                          corner;
      logic        [FRAC_BITS-1:0]   fx;
      logic        [FRAC_BITS-1:0]   fz;
   } height_word_type;

endpackage

### rtl/ths_ram.sv
`timescale 1ns / 1ps

module ths_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [(2**ADDR_W)-1:0];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/ths_cfg.sv
`timescale 1ns / 1ps

module ths_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ths_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ths_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output ths_pkg::cfg_type                    cfg
);

   logic        [ths_pkg::SCALE_BITS-1:0]  inv_scale_ff;
   logic        [ths_pkg::UPOS_BITS-1:0]   world_size_ff;
   logic        [ths_pkg::SIDE_BITS-1:0]   side_ff;
   logic        [ths_pkg::SIDE_BITS-1:0]   side_in;
   logic        [ths_pkg::SIDE_BITS-1:0]   side_m1;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] cam_height_ff;

   // grid side held to the supported range on write
   always_comb begin
      side_in = csr_data[ths_pkg::SIDE_BITS-1:0];
      if (side_in < ths_pkg::SIDE_BITS'(ths_pkg::SIDE_MIN)) begin
         side_in = ths_pkg::SIDE_BITS'(ths_pkg::SIDE_MIN);
      end else if (side_in > ths_pkg::SIDE_BITS'(ths_pkg::GRID_SIDE_MAX)) begin
         side_in = ths_pkg::SIDE_BITS'(ths_pkg::GRID_SIDE_MAX);
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff  <= ths_pkg::INV_SCALE_RESET;
         world_size_ff <= ths_pkg::WORLD_SIZE_RESET;
         side_ff       <= ths_pkg::GRID_SIDE_RESET;
         cam_height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ths_pkg::CSR_INV_SCALE: begin
               inv_scale_ff <= csr_data[ths_pkg::SCALE_BITS-1:0];
            end
            ths_pkg::CSR_WORLD_SIZE: begin
               world_size_ff <= csr_data[ths_pkg::UPOS_BITS-1:0];
            end
            ths_pkg::CSR_GRID_SIDE: begin
               side_ff <= side_in;
            end
            ths_pkg::CSR_CAM_HEIGHT: begin
               cam_height_ff <= $signed(csr_data[ths_pkg::HEIGHT_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // last valid row or column index
   assign side_m1 = side_ff - ths_pkg::SIDE_BITS'(1);

   assign cfg.inv_scale  = inv_scale_ff;
   assign cfg.world_size = world_size_ff;
   assign cfg.side       = side_ff;
   assign cfg.side_m1    = side_m1[ths_pkg::IDX_BITS-1:0];
   assign cfg.cam_height = cam_height_ff;

endmodule

### rtl/ths_coord.sv
`timescale 1ns / 1ps

module ths_coord (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ths_pkg::cfg_type                       cfg,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic        [ths_pkg::ADDR_BITS-1:0]   req_sample_index,
   input  logic signed [ths_pkg::HEIGHT_BITS-1:0] req_sample_value,
   input  logic signed [ths_pkg::POS_BITS-1:0]    req_cam_x,
   input  logic signed [ths_pkg::POS_BITS-1:0]    req_cam_z,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output ths_pkg::addr_word_type                 out_word
);

   // clamp one camera coordinate into the world
   function automatic logic [ths_pkg::UPOS_BITS-1:0] clamp_coord(
      input logic signed [ths_pkg::POS_BITS-1:0]  c,
      input logic        [ths_pkg::UPOS_BITS-1:0] ws
   );
      logic [ths_pkg::UPOS_BITS-1:0] r;
      if (c[ths_pkg::POS_BITS-1]) begin
         r = '0;
      end else if (c[ths_pkg::UPOS_BITS-1:0] >= ws) begin
         r = (ws >= ths_pkg::POS_HALF) ? ws - ths_pkg::POS_HALF : '0;
      end else begin
         r = c[ths_pkg::UPOS_BITS-1:0];
      end
      return r;
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic hold1, hold2, hold3, hold4, hold5;

   logic                                 s1_query_ff;
   logic [ths_pkg::ADDR_BITS-1:0]        s1_index_ff;
   logic [ths_pkg::HEIGHT_BITS-1:0]      s1_value_ff;
   logic signed [ths_pkg::POS_BITS-1:0]  s1_x_ff;
   logic signed [ths_pkg::POS_BITS-1:0]  s1_z_ff;

   logic                                 s2_query_ff;
   logic [ths_pkg::ADDR_BITS-1:0]        s2_index_ff;
   logic [ths_pkg::HEIGHT_BITS-1:0]      s2_value_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s2_px_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s2_pz_ff;

   logic                                 s3_query_ff;
   logic [ths_pkg::ADDR_BITS-1:0]        s3_index_ff;
   logic [ths_pkg::HEIGHT_BITS-1:0]      s3_value_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s3_px_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s3_pz_ff;
   logic [ths_pkg::GRID_BITS-1:0]        s3_gx_ff;
   logic [ths_pkg::GRID_BITS-1:0]        s3_gz_ff;

   logic [ths_pkg::INT_BITS-1:0]         ix;
   logic [ths_pkg::INT_BITS-1:0]         iz;
   logic                                 edge_x;
   logic                                 edge_z;
   logic [ths_pkg::IDX_BITS-1:0]         cx_in;
   logic [ths_pkg::IDX_BITS-1:0]         cz_in;

   logic                                 s4_query_ff;
   logic [ths_pkg::ADDR_BITS-1:0]        s4_index_ff;
   logic [ths_pkg::HEIGHT_BITS-1:0]      s4_value_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s4_px_ff;
   logic [ths_pkg::UPOS_BITS-1:0]        s4_pz_ff;
   logic [ths_pkg::IDX_BITS-1:0]         s4_cx_ff;
   logic [ths_pkg::IDX_BITS-1:0]         s4_cz_ff;
   logic                                 s4_corner_ff;
   logic [ths_pkg::FRAC_BITS-1:0]        s4_fx_ff;
   logic [ths_pkg::FRAC_BITS-1:0]        s4_fz_ff;

   logic [ths_pkg::IDX_BITS+ths_pkg::SIDE_BITS-1:0] row_base;
   logic [ths_pkg::IDX_BITS+ths_pkg::SIDE_BITS-1:0] base_sum;
   ths_pkg::addr_word_type               s5_in;
   ths_pkg::addr_word_type               s5_ff;

   // a stage holds its word while the stage after it is held
   assign hold5     = v5_ff & out_stall;
   assign hold4     = v4_ff & hold5;
   assign hold3     = v3_ff & hold4;
   assign hold2     = v2_ff & hold3;
   assign hold1     = v1_ff & hold2;
   assign req_stall = hold1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (!hold1) v1_ff <= req_valid;
         if (!hold2) v2_ff <= v1_ff;
         if (!hold3) v3_ff <= v2_ff;
         if (!hold4) v4_ff <= v3_ff;
         if (!hold5) v5_ff <= v4_ff;
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (!hold1) begin
         s1_query_ff <= (req_opcode == ths_pkg::OP_QUERY);
         s1_index_ff <= req_sample_index;
         s1_value_ff <= req_sample_value;
         s1_x_ff     <= req_cam_x;
         s1_z_ff     <= req_cam_z;
      end
   end

   // stage 2: clamp into the world
   always_ff @(posedge clock) begin
      if (!hold2) begin
         s2_query_ff <= s1_query_ff;
         s2_index_ff <= s1_index_ff;
         s2_value_ff <= s1_value_ff;
         s2_px_ff    <= clamp_coord(s1_x_ff, cfg.world_size);
         s2_pz_ff    <= clamp_coord(s1_z_ff, cfg.world_size);
      end
   end

   // stage 3: scale to grid units
   always_ff @(posedge clock) begin
      if (!hold3) begin
         s3_query_ff <= s2_query_ff;
         s3_index_ff <= s2_index_ff;
         s3_value_ff <= s2_value_ff;
         s3_px_ff    <= s2_px_ff;
         s3_pz_ff    <= s2_pz_ff;
         s3_gx_ff    <= ths_pkg::GRID_BITS'(s2_px_ff) * ths_pkg::GRID_BITS'(cfg.inv_scale);
         s3_gz_ff    <= ths_pkg::GRID_BITS'(s2_pz_ff) * ths_pkg::GRID_BITS'(cfg.inv_scale);
      end
   end

   // stage 4: split into grid index and fraction, hold at the far edge
   assign ix     = s3_gx_ff[ths_pkg::GRID_BITS-1:ths_pkg::SCALE_FRAC];
   assign iz     = s3_gz_ff[ths_pkg::GRID_BITS-1:ths_pkg::SCALE_FRAC];
   assign edge_x = ix >= ths_pkg::INT_BITS'(cfg.side_m1);
   assign edge_z = iz >= ths_pkg::INT_BITS'(cfg.side_m1);
   assign cx_in  = edge_x ? cfg.side_m1 : ix[ths_pkg::IDX_BITS-1:0];
   assign cz_in  = edge_z ? cfg.side_m1 : iz[ths_pkg::IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (!hold4) begin
         s4_query_ff  <= s3_query_ff;
         s4_index_ff  <= s3_index_ff;
         s4_value_ff  <= s3_value_ff;
         s4_px_ff     <= s3_px_ff;
         s4_pz_ff     <= s3_pz_ff;
         s4_cx_ff     <= cx_in;
         s4_cz_ff     <= cz_in;
         s4_corner_ff <= edge_x | edge_z;
         s4_fx_ff     <= s3_gx_ff[ths_pkg::SCALE_FRAC-1 -: ths_pkg::FRAC_BITS];
         s4_fz_ff     <= s3_gz_ff[ths_pkg::SCALE_FRAC-1 -: ths_pkg::FRAC_BITS];
      end
   end

   // stage 5: store addresses of the four neighbours
   assign row_base = s4_cz_ff * cfg.side;
   assign base_sum = row_base + (ths_pkg::IDX_BITS + ths_pkg::SIDE_BITS)'(s4_cx_ff);

   always_comb begin
      s5_in.is_query = s4_query_ff;
      s5_in.wr_addr  = s4_index_ff;
      s5_in.wr_data  = s4_value_ff;
      s5_in.px       = s4_px_ff;
      s5_in.pz       = s4_pz_ff;
      s5_in.a00      = base_sum[ths_pkg::ADDR_BITS-1:0];
      s5_in.a10      = s5_in.a00 + ths_pkg::ADDR_BITS'(1);
      s5_in.a01      = s5_in.a00 + ths_pkg::ADDR_BITS'(cfg.side);
      s5_in.a11      = s5_in.a01 + ths_pkg::ADDR_BITS'(1);
      s5_in.corner   = s4_corner_ff;
      s5_in.fx       = s4_fx_ff;
      s5_in.fz       = s4_fz_ff;
   end

   always_ff @(posedge clock) begin
      if (!hold5) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_word  = s5_ff;

endmodule

### rtl/ths_blend.sv
`timescale 1ns / 1ps

module ths_blend (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ths_pkg::cfg_type                       cfg,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  ths_pkg::height_word_type               in_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [ths_pkg::UPOS_BITS-1:0]   rsp_out_x,
   output logic        [ths_pkg::UPOS_BITS-1:0]   rsp_out_z,
   output logic signed [ths_pkg::HEIGHT_BITS-1:0] rsp_out_y
);

   // floor((a*(S-f) + b*f) / S) written as a*S + (b-a)*f
   function automatic logic signed [ths_pkg::HEIGHT_BITS-1:0] lerp(
      input logic signed [ths_pkg::HEIGHT_BITS-1:0] a,
      input logic signed [ths_pkg::HEIGHT_BITS-1:0] b,
      input logic        [ths_pkg::FRAC_BITS-1:0]   f
   );
      logic signed [ths_pkg::HEIGHT_BITS:0]    diff;
      logic signed [ths_pkg::BLEND_BITS-1:0]   acc;
      diff = $signed({b[ths_pkg::HEIGHT_BITS-1], b}) - $signed({a[ths_pkg::HEIGHT_BITS-1], a});
      acc  = (ths_pkg::BLEND_BITS'(a) <<< ths_pkg::FRAC_BITS)
           + diff * $signed({1'b0, f});
      return acc[ths_pkg::FRAC_BITS +: ths_pkg::HEIGHT_BITS];
   endfunction

   logic v7_ff, v8_ff, v9_ff;
   logic hold7, hold8, hold9;

   logic        [ths_pkg::UPOS_BITS-1:0]   s7_px_ff;
   logic        [ths_pkg::UPOS_BITS-1:0]   s7_pz_ff;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] s7_bottom_ff;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] s7_top_ff;
   logic                                   s7_corner_ff;
   logic        [ths_pkg::FRAC_BITS-1:0]   s7_fz_ff;

   logic        [ths_pkg::UPOS_BITS-1:0]   s8_px_ff;
   logic        [ths_pkg::UPOS_BITS-1:0]   s8_pz_ff;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] s8_h_ff;

   logic signed [ths_pkg::HEIGHT_BITS:0]   sum;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] y_in;

   logic        [ths_pkg::UPOS_BITS-1:0]   s9_px_ff;
   logic        [ths_pkg::UPOS_BITS-1:0]   s9_pz_ff;
   logic signed [ths_pkg::HEIGHT_BITS-1:0] s9_y_ff;

   // the output register frees as soon as its word is taken
   assign hold9    = v9_ff & rsp_stall;
   assign hold8    = v8_ff & hold9;
   assign hold7    = v7_ff & hold8;
   assign in_stall = hold7;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         if (!hold7) v7_ff <= in_valid;
         if (!hold8) v8_ff <= v7_ff;
         if (!hold9) v9_ff <= v8_ff;
      end
   end

   // stage 7: blend along x on both rows; a corner word keeps h00 as its bottom value
   always_ff @(posedge clock) begin
      if (!hold7) begin
         s7_px_ff     <= in_word.px;
         s7_pz_ff     <= in_word.pz;
         s7_bottom_ff <= in_word.corner ? in_word.h00
                                        : lerp(in_word.h00, in_word.h10, in_word.fx);
         s7_top_ff    <= lerp(in_word.h01, in_word.h11, in_word.fx);
         s7_corner_ff <= in_word.corner;
         s7_fz_ff     <= in_word.fz;
      end
   end

   // stage 8: blend between rows, corner sample passes straight
   always_ff @(posedge clock) begin
      if (!hold8) begin
         s8_px_ff <= s7_px_ff;
         s8_pz_ff <= s7_pz_ff;
         s8_h_ff  <= s7_corner_ff ? s7_bottom_ff : lerp(s7_bottom_ff, s7_top_ff, s7_fz_ff);
      end
   end

   // stage 9: add camera height and saturate
   assign sum = $signed({s8_h_ff[ths_pkg::HEIGHT_BITS-1], s8_h_ff})
              + $signed({cfg.cam_height[ths_pkg::HEIGHT_BITS-1], cfg.cam_height});

   always_comb begin
      if (sum[ths_pkg::HEIGHT_BITS] != sum[ths_pkg::HEIGHT_BITS-1]) begin
         y_in = sum[ths_pkg::HEIGHT_BITS] ? ths_pkg::H_MIN : ths_pkg::H_MAX;
      end else begin
         y_in = sum[ths_pkg::HEIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold9) begin
         s9_px_ff <= s8_px_ff;
         s9_pz_ff <= s8_pz_ff;
         s9_y_ff  <= y_in;
      end
   end

   assign rsp_valid = v9_ff;
   assign rsp_out_x = s9_px_ff;
   assign rsp_out_z = s9_pz_ff;
   assign rsp_out_y = s9_y_ff;

endmodule

### rtl/terrain_height_sampler_top.sv
`timescale 1ns / 1ps

// Height-map sampler: write words (opcode 0) load one height sample into the
// 65536-entry store; query words (opcode 1) clamp the camera x and z into the
// world, scale them to grid units, blend the four neighbouring samples and
// return the clamped position with the terrain height plus camera height.
// One word is taken every cycle when the result side keeps up; a query passes
// nine register stages before its result word is presented. The four neighbour
// reads per query come from two copies of the height store, each with two read
// ports, both written by every write word. Writes and reads reach the store in
// arrival order, so a query sees every write taken before it. Samples must be
// written before a query reads them. Configuration must be changed only while
// the block is idle; the block itself does not enforce this.

module terrain_height_sampler_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic        [ths_pkg::ADDR_BITS-1:0]   req_sample_index,
   input  logic signed [ths_pkg::HEIGHT_BITS-1:0] req_sample_value,
   input  logic signed [ths_pkg::POS_BITS-1:0]    req_cam_x,
   input  logic signed [ths_pkg::POS_BITS-1:0]    req_cam_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [ths_pkg::UPOS_BITS-1:0]   rsp_out_x,
   output logic        [ths_pkg::UPOS_BITS-1:0]   rsp_out_z,
   output logic signed [ths_pkg::HEIGHT_BITS-1:0] rsp_out_y,
   input  logic                                   csr_we,
   input  logic        [ths_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic        [ths_pkg::CSR_DATA_BITS-1:0] csr_data
);

   ths_pkg::cfg_type                   cfg;
   logic                               a_valid;
   ths_pkg::addr_word_type             a_word;
   logic                               v6_ff;
   logic                               hold6;
   logic                               blend_stall;
   logic                               rd_en;
   logic                               wr_en;
   logic [ths_pkg::HEIGHT_BITS-1:0]    h00;
   logic [ths_pkg::HEIGHT_BITS-1:0]    h10;
   logic [ths_pkg::HEIGHT_BITS-1:0]    h01;
   logic [ths_pkg::HEIGHT_BITS-1:0]    h11;
   logic [ths_pkg::UPOS_BITS-1:0]      s6_px_ff;
   logic [ths_pkg::UPOS_BITS-1:0]      s6_pz_ff;
   logic                               s6_corner_ff;
   logic [ths_pkg::FRAC_BITS-1:0]      s6_fx_ff;
   logic [ths_pkg::FRAC_BITS-1:0]      s6_fz_ff;
   ths_pkg::height_word_type           h_word;

   // configuration registers
   ths_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // clamp, scale and address pipe
   ths_coord u_coord (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_sample_index (req_sample_index),
      .req_sample_value (req_sample_value),
      .req_cam_x        (req_cam_x),
      .req_cam_z        (req_cam_z),
      .out_valid        (a_valid),
      .out_stall        (hold6),
      .out_word         (a_word)
   );

   // store access stage: a word moves on when this stage is free
   assign hold6 = v6_ff & blend_stall;
   assign rd_en = !hold6;
   assign wr_en = a_valid & !a_word.is_query & !hold6;

   // lower row copy of the height store
   ths_ram #(
      .ADDR_W (ths_pkg::ADDR_BITS),
      .DATA_W (ths_pkg::HEIGHT_BITS)
   ) u_ram_lo (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (a_word.wr_addr),
      .wr_data   (a_word.wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (a_word.a00),
      .rd_addr_b (a_word.a10),
      .rd_data_a (h00),
      .rd_data_b (h10)
   );

   // upper row copy of the height store
   ths_ram #(
      .ADDR_W (ths_pkg::ADDR_BITS),
      .DATA_W (ths_pkg::HEIGHT_BITS)
   ) u_ram_hi (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (a_word.wr_addr),
      .wr_data   (a_word.wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (a_word.a01),
      .rd_addr_b (a_word.a11),
      .rd_data_a (h01),
      .rd_data_b (h11)
   );

   // write words end here, only queries go on
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (!hold6) begin
         v6_ff <= a_valid & a_word.is_query;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold6) begin
         s6_px_ff     <= a_word.px;
         s6_pz_ff     <= a_word.pz;
         s6_corner_ff <= a_word.corner;
         s6_fx_ff     <= a_word.fx;
         s6_fz_ff     <= a_word.fz;
      end
   end

   assign h_word.px     = s6_px_ff;
   assign h_word.pz     = s6_pz_ff;
   assign h_word.h00    = $signed(h00);
   assign h_word.h10    = $signed(h10);
   assign h_word.h01    = $signed(h01);
   assign h_word.h11    = $signed(h11);
   assign h_word.corner = s6_corner_ff;
   assign h_word.fx     = s6_fx_ff;
   assign h_word.fz     = s6_fz_ff;

   // bilinear blend and output register
   ths_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (v6_ff),
      .in_stall  (blend_stall),
      .in_word   (h_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_z (rsp_out_z),
      .rsp_out_y (rsp_out_y)
   );

endmodule
